>>> src/ordered_value_list_engine_top_defines.svh
// Assertion macros shared by the verification checkers of the value list engine.
// Depends on nothing; each macro expects a clock and an active-low reset by name.
`ifndef ORDERED_VALUE_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_VALUE_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define OVLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ovle checker: same-cycle property failed");

// Next-cycle implication, switched off while reset is held.
`define OVLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ovle checker: next-cycle property failed");

// Property that must follow any clock edge taken with reset held.
`define OVLE_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("ovle checker: post-reset property failed");

`endif

>>> src/ovle_pkg.sv
// Shared constants, codes and controller/datapath interface types of the value list engine.
// Depends on nothing; every other source file but the defines header imports it.
package ovle_pkg;

    // Storage geometry.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int SUM_W    = DATA_W + CNT_W;
    localparam int STEP_W   = $clog2(SUM_W + 1);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Field widths of the stream beats.
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 7;
    localparam int IN_W        = CMD_W + 2 * DATA_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = STATUS_W + POS_W + COUNT_W + 3 * DATA_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [CMD_W-1:0] {
        OP_APPEND,
        OP_EDIT,
        OP_DELETE,
        OP_SEARCH
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE,
        ST_NO_MATCH,
        ST_FULL
    } t_status;

    // What a sweep over the stored entries does with each entry it reads.
    typedef enum logic [1:0] {
        SW_FIND,
        SW_SHIFT,
        SW_STATS
    } t_sweep;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_FIND_GO,
        S_FIND,
        S_EDIT,
        S_SHIFT_GO,
        S_SHIFT,
        S_SHRINK,
        S_STATS_GO,
        S_STATS,
        S_DIV_GO,
        S_DIV,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load;
        logic   append;
        logic   edit;
        logic   shrink;
        logic   sweep_start;
        logic   sweep_run;
        t_sweep mode;
        logic   div_start;
        logic   out_load;
    } t_ctrl_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        t_op  op;
        logic found;
        logic sweep_done;
        logic div_done;
        logic out_free;
    } t_ctrl_stat;

endpackage

>>> src/ovle_ctrl.sv
// Controller state machine of the value list engine: sequences load, sweeps, divide and output.
// Depends on ovle_pkg for the state enum and the command and status structs.
module ovle_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ovle_pkg::t_ctrl_stat  i_stat,
    output ovle_pkg::t_ctrl_cmd   o_cmd
);
    import ovle_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FIND_GO;
                end
            end
            S_APPEND:   n_state = S_STATS_GO;
            S_FIND_GO: begin
                // An append does not search; the opcode is registered by now.
                n_state = (i_stat.op == OP_APPEND) ? S_APPEND : S_FIND;
            end
            S_FIND: begin
                if (i_stat.sweep_done) begin
                    if (!i_stat.found) begin
                        n_state = S_STATS_GO;
                    end else begin
                        case (i_stat.op)
                            OP_EDIT:   n_state = S_EDIT;
                            OP_DELETE: n_state = S_SHIFT_GO;
                            default:   n_state = S_STATS_GO;
                        endcase
                    end
                end
            end
            S_EDIT:     n_state = S_STATS_GO;
            S_SHIFT_GO: n_state = S_SHIFT;
            S_SHIFT: begin
                if (i_stat.sweep_done) begin
                    n_state = S_SHRINK;
                end
            end
            S_SHRINK:   n_state = S_STATS_GO;
            S_STATS_GO: n_state = S_STATS;
            S_STATS: begin
                if (i_stat.sweep_done) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO:   n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Output logic.
    always_comb begin
        o_cmd      = '0;
        o_cmd.mode = SW_FIND;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_APPEND:   o_cmd.append = 1'b1;
            S_FIND_GO: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.mode        = SW_FIND;
            end
            S_FIND: begin
                o_cmd.sweep_run = 1'b1;
                o_cmd.mode      = SW_FIND;
            end
            S_EDIT:     o_cmd.edit = 1'b1;
            S_SHIFT_GO: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.mode        = SW_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.sweep_run = 1'b1;
                o_cmd.mode      = SW_SHIFT;
            end
            S_SHRINK:   o_cmd.shrink = 1'b1;
            S_STATS_GO: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.mode        = SW_STATS;
            end
            S_STATS: begin
                o_cmd.sweep_run = 1'b1;
                o_cmd.mode      = SW_STATS;
            end
            S_DIV_GO:   o_cmd.div_start = 1'b1;
            S_DIV:      o_cmd.div_start = 1'b0;
            S_OUT:      o_cmd.out_load = i_stat.out_free;
            default:    o_cmd.load = 1'b0;
        endcase
    end

endmodule

>>> src/ovle_div.sv
// Restoring divider of the value list engine: signed sum over entry count, one bit per cycle.
// Depends on ovle_pkg for the sum, count and data widths.
module ovle_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_neg,
    input  logic [ovle_pkg::SUM_W-1:0]    i_mag,
    input  logic [ovle_pkg::CNT_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [ovle_pkg::DATA_W-1:0]   o_quotient
);
    import ovle_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;

    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_diff;
    logic              fits;
    logic [SUM_W-1:0]  quo_signed;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, i_divisor};
    assign fits     = (rem_sh >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_step == STEP_W'(SUM_W - 1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_rem  <= '0;
            r_quo  <= i_mag;
            r_neg  <= i_neg;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            r_rem  <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_quo  <= {r_quo[SUM_W-2:0], fits};
        end
    end

    // Truncation toward zero: divide magnitudes, then restore the sign.
    assign quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_quotient = quo_signed[DATA_W-1:0];
    assign o_done     = r_done;

endmodule

>>> src/ovle_dp.sv
// Datapath of the value list engine: entry memory, count, sweep engine, statistics, output.
// Depends on ovle_pkg and instantiates ovle_div for the average.
module ovle_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ovle_pkg::t_ctrl_cmd               i_cmd,
    output ovle_pkg::t_ctrl_stat              o_stat,
    input  logic [ovle_pkg::IN_TDATA_W-1:0]   i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ovle_pkg::OUT_TDATA_W-1:0]  o_out_data
);
    import ovle_pkg::*;

    // Entry store: one write and one registered read per cycle.
    logic [DATA_W-1:0]        r_mem [CAPACITY];
    logic [DATA_W-1:0]        r_rd_data;

    t_op                      r_op;
    logic [DATA_W-1:0]        r_key;
    logic [DATA_W-1:0]        r_new;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_idx;
    logic [CNT_W-1:0]         r_didx;
    logic                     r_dv;
    logic                     r_found;
    logic [CNT_W-1:0]         r_hit;
    logic                     r_full;
    logic signed [DATA_W-1:0] r_max;
    logic signed [DATA_W-1:0] r_min;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;

    logic                     issue;
    logic                     find_hold;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [CNT_W-1:0]         prev_idx;
    logic signed [DATA_W-1:0] rd_val;
    logic signed [SUM_W-1:0]  rd_ext;
    logic [SUM_W-1:0]         sum_mag;
    logic                     div_done;
    logic [DATA_W-1:0]        div_q;
    logic                     out_free;
    t_status                  res_status;
    logic [POS_W-1:0]         res_pos;
    logic [DATA_W-1:0]        res_avg;

    // Sweep issue: one read per cycle until the count, or until a search has matched.
    assign find_hold = (i_cmd.mode == SW_FIND) && r_found;
    assign issue     = i_cmd.sweep_run && (r_idx < r_count) && !find_hold;
    assign prev_idx  = r_didx - CNT_W'(1);
    assign rd_val    = $signed(r_rd_data);
    assign rd_ext    = SUM_W'(rd_val);

    // Single write port: append at the tail, edit at the hit, shift one place toward the head.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[ADDR_W-1:0];
        wr_data = r_key;
        if (i_cmd.append) begin
            wr_en   = (r_count < CAP_CNT);
        end else if (i_cmd.edit) begin
            wr_en   = 1'b1;
            wr_addr = r_hit[ADDR_W-1:0];
            wr_data = r_new;
        end else if (i_cmd.sweep_run && (i_cmd.mode == SW_SHIFT) && r_dv) begin
            wr_en   = 1'b1;
            wr_addr = prev_idx[ADDR_W-1:0];
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    // Command beat capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_in_data[CMD_W-1:0]);
            r_key <= i_in_data[CMD_W +: DATA_W];
            r_new <= i_in_data[CMD_W + DATA_W +: DATA_W];
        end
    end

    // Entry count, full flag and match flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_full  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_full  <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.append) begin
                if (r_count < CAP_CNT) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_full <= 1'b1;
                end
            end
            if (i_cmd.shrink) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.sweep_run && (i_cmd.mode == SW_FIND) && r_dv && !r_found
                && (r_rd_data == r_key)) begin
                r_found <= 1'b1;
            end
        end
    end

    // Sweep index and read-data valid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (i_cmd.sweep_start) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start) begin
            r_idx <= (i_cmd.mode == SW_SHIFT) ? (r_hit + CNT_W'(1)) : '0;
        end else if (issue) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        r_didx <= r_idx;
    end

    // Position of the first match.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_run && (i_cmd.mode == SW_FIND) && r_dv && !r_found
            && (r_rd_data == r_key)) begin
            r_hit <= r_didx;
        end
    end

    // Running maximum, minimum and sum over the stored entries.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start && (i_cmd.mode == SW_STATS)) begin
            r_max <= INT_MIN;
            r_min <= INT_MAX;
            r_sum <= '0;
        end else if (i_cmd.sweep_run && (i_cmd.mode == SW_STATS) && r_dv) begin
            if (rd_val > r_max) begin
                r_max <= rd_val;
            end
            if (rd_val < r_min) begin
                r_min <= rd_val;
            end
            r_sum <= r_sum + rd_ext;
        end
    end

    // Sweep completion as seen by the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.found      = r_found;
        o_stat.sweep_done = find_hold || (!r_dv && (r_idx >= r_count));
        o_stat.div_done   = div_done;
        o_stat.out_free   = out_free;
    end

    // Average: magnitude of the sum over the count, sign restored in the divider.
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    ovle_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_neg      (r_sum[SUM_W-1]),
        .i_mag      (sum_mag),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Result fields.
    always_comb begin
        res_status = ST_DONE;
        res_pos    = '0;
        if (r_full) begin
            res_status = ST_FULL;
        end else if (r_op != OP_APPEND) begin
            if (r_found) begin
                res_pos = POS_W'(r_hit);
            end else begin
                res_status = ST_NO_MATCH;
            end
        end
    end

    assign res_avg = (r_count == '0) ? '0 : div_q;

    // Output register: holds a finished result until the downstream side takes it.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {{(OUT_TDATA_W - OUT_W){1'b0}}, res_avg, r_min, r_max,
                           COUNT_W'(r_count), res_pos, res_status};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> src/ordered_value_list_engine_top.sv
// Top level of the ordered value list engine: joins the controller and the datapath.
// Depends on ovle_pkg, ovle_ctrl, ovle_dp and ovle_div.
//
//   Channel  Dir  Beat contents (lowest bits first)
//   s_axis   in   cmd[1:0], key_value[33:2], new_value[65:34], zero fill to 72 bits
//   m_axis   out  status[1:0], position[7:2], entry_count[14:8], max_value[46:15],
//                 min_value[78:47], average[110:79], zero fill to 112 bits
//
// One command at a time. Each command sweeps the stored entries one or more times through
// the single read port of the entry memory (one entry per cycle per sweep), then runs the
// one-bit-per-cycle divider for the average. Synchronous active-low reset empties
// the store; no clearing pass. A new command beat is taken while the previous result still
// waits in the output register; a stalled output keeps the controller in its output state,
// with the next result held in the datapath, until the register frees.
module ordered_value_list_engine_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cmd, key_value, new_value
    input  logic [ovle_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status, position, entry_count, max_value, min_value, average
    output logic [ovle_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ovle_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_ctrl_stat ctrl_stat;

    // Command sequencing.
    ovle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (ctrl_stat),
        .o_cmd      (ctrl_cmd)
    );

    // Storage, statistics and result register.
    ovle_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_stat      (ctrl_stat),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> src/ovle_checker.sv
// Port-level checker of the ordered value list engine, bound to the top level.
// Depends on ovle_pkg and on the assertion macros of the top-level defines header.
`include "ordered_value_list_engine_top_defines.svh"

module ovle_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [ovle_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ovle_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ovle_pkg::*;

    logic [STATUS_W-1:0] res_status;
    logic [POS_W-1:0]    res_pos;
    logic [COUNT_W-1:0]  res_count;
    logic [DATA_W-1:0]   res_max;
    logic [DATA_W-1:0]   res_min;
    logic [DATA_W-1:0]   res_avg;
    logic                in_beat;

    // Result fields of the output beat.
    assign res_status = m_axis_tdata[STATUS_W-1:0];
    assign res_pos    = m_axis_tdata[STATUS_W +: POS_W];
    assign res_count  = m_axis_tdata[STATUS_W + POS_W +: COUNT_W];
    assign res_max    = m_axis_tdata[STATUS_W + POS_W + COUNT_W +: DATA_W];
    assign res_min    = m_axis_tdata[STATUS_W + POS_W + COUNT_W + DATA_W +: DATA_W];
    assign res_avg    = m_axis_tdata[STATUS_W + POS_W + COUNT_W + 2 * DATA_W +: DATA_W];
    assign in_beat    = s_axis_tvalid && s_axis_tready && (s_axis_tdata[CMD_W-1:0] != '0
                        || s_axis_tdata[CMD_W-1:0] == '0);

    // A stalled result stays put.
    `OVLE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // The controller takes no second command right after one was accepted.
    `OVLE_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_beat, !s_axis_tready)

    // Only a successful match reports a position.
    `OVLE_ASSERT_NOW(a_pos_zero, i_clk, i_rst_n, m_axis_tvalid && (res_status != ST_DONE), res_pos == '0)

    // The count never passes the capacity, and an empty store reports the empty statistics.
    `OVLE_ASSERT_NOW(a_count_range, i_clk, i_rst_n, m_axis_tvalid, res_count <= COUNT_W'(CAPACITY))
    `OVLE_ASSERT_NOW(a_empty_stats, i_clk, i_rst_n, m_axis_tvalid && (res_count == '0), (res_max == INT_MIN) && (res_min == INT_MAX) && (res_avg == '0))

endmodule

bind ordered_value_list_engine_top ovle_checker u_ovle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb.sv
// Self-checking testbench for the ordered value list engine: stream driver, stream monitor,
// and a scoreboard that predicts each result beat. Depends on ovle_pkg and the engine top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ovle_pkg::*;

    // One command beat and one result beat, in the engine's field widths.
    typedef struct {
        t_op                      op;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] repl;
    } t_list_cmd;

    typedef struct {
        t_status                  status;
        logic [POS_W-1:0]         pos;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] maxv;
        logic signed [DATA_W-1:0] minv;
        logic signed [DATA_W-1:0] avg;
    } t_list_result;

    typedef enum int {
        TR_STEADY,
        TR_SRC_SLOW,
        TR_SNK_SLOW,
        TR_BOTH_SLOW
    } t_traffic;

    localparam int POOL_SIZE    = 12;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 300;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // cmd, key_value, new_value
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // status, position, entry_count, max_value, min_value, average
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_list_cmd    pending_cmds[$];
    t_list_result expected_results[$];
    t_list_cmd    offered_cmd;

    // Shadow copy of the stored list.
    logic signed [DATA_W-1:0] list_vals [CAPACITY];
    int                       list_len = 0;

    logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

    int   src_idle_pct  = 0;
    int   snk_stall_pct = 0;
    logic sink_hold     = 1'b0;
    int   phase_num     = 0;
    int   mismatches    = 0;

    ordered_value_list_engine_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Applies one command to the shadow list and returns the result beat it should produce.
    function automatic t_list_result apply_list_cmd(input t_list_cmd c);
        t_list_result r;
        int           hit;
        longint       sum;
        r.status = ST_DONE;
        r.pos    = '0;
        hit      = -1;
        if (c.op == OP_APPEND) begin
            if (list_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                list_vals[list_len] = c.key;
                list_len++;
            end
        end else begin
            // Only the first (lowest index) match counts.
            for (int i = 0; i < list_len; i++) begin
                if (hit < 0 && list_vals[i] == c.key) hit = i;
            end
            if (hit < 0) begin
                r.status = ST_NO_MATCH;
            end else begin
                r.pos = POS_W'(hit);
                if (c.op == OP_EDIT) begin
                    list_vals[hit] = c.repl;
                end else if (c.op == OP_DELETE) begin
                    for (int i = hit; i < list_len - 1; i++) list_vals[i] = list_vals[i + 1];
                    list_len--;
                end
            end
        end
        // Statistics over what is stored after the command.
        r.maxv = INT_MIN;
        r.minv = INT_MAX;
        sum    = 0;
        for (int i = 0; i < list_len; i++) begin
            if (list_vals[i] > r.maxv) r.maxv = list_vals[i];
            if (list_vals[i] < r.minv) r.minv = list_vals[i];
            sum += list_vals[i];
        end
        r.count = COUNT_W'(list_len);
        r.avg   = (list_len > 0) ? DATA_W'(sum / list_len) : '0;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(input int pool_pct);
        if (chance(pool_pct)) return value_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic t_list_cmd random_list_cmd(input int app_pct, input int del_pct,
                                                  input int edit_pct);
        t_list_cmd c;
        int        roll;
        roll   = $urandom_range(99);
        c.op   = (roll < app_pct) ? OP_APPEND :
                 (roll < app_pct + del_pct) ? OP_DELETE :
                 (roll < app_pct + del_pct + edit_pct) ? OP_EDIT : OP_SEARCH;
        // Mostly pool values so that matches and duplicates are common.
        c.key  = pick_value(80);
        c.repl = pick_value(50);
        return c;
    endfunction

    task automatic queue_cmd(input t_op op, input logic signed [DATA_W-1:0] key,
                             input logic signed [DATA_W-1:0] repl);
        t_list_cmd c;
        c.op   = op;
        c.key  = key;
        c.repl = repl;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_traffic(input t_traffic mode);
        case (mode)
            TR_STEADY: begin
                src_idle_pct  <= 0;
                snk_stall_pct <= 0;
            end
            TR_SRC_SLOW: begin
                src_idle_pct  <= 82;
                snk_stall_pct <= 0;
            end
            TR_SNK_SLOW: begin
                src_idle_pct  <= 0;
                snk_stall_pct <= 82;
            end
            default: begin
                src_idle_pct  <= 11;
                snk_stall_pct <= 11;
            end
        endcase
    endtask

    task automatic report_field(input string name, input logic signed [63:0] exp_val,
                                input logic signed [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            mismatches++;
        end
    endtask

    // Command driver: predicts on each accepted beat, then offers the next pending command.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_list_cmd(offered_cmd));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() != 0 && !chance(src_idle_pct)) begin
                    offered_cmd = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'({offered_cmd.repl, offered_cmd.key,
                                                  offered_cmd.op});
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with no command pending, actual %0h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    exp_r = expected_results.pop_front();
                    report_field("status", exp_r.status, m_axis_tdata[1:0]);
                    report_field("position", exp_r.pos, m_axis_tdata[7:2]);
                    report_field("entry_count", exp_r.count, m_axis_tdata[14:8]);
                    report_field("max_value", exp_r.maxv, $signed(m_axis_tdata[46:15]));
                    report_field("min_value", exp_r.minv, $signed(m_axis_tdata[78:47]));
                    report_field("average", exp_r.avg, $signed(m_axis_tdata[110:79]));
                end
            end
            m_axis_tready <= !sink_hold && !chance(snk_stall_pct);
        end
    end

    // Long receiver hold-off at the start of the first random phase, so the input backs up.
    initial begin
        wait (phase_num == 1);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // Watchdog.
    initial begin
        #8_000_000;
        $display("tb failed");
        $finish;
    end

    // Stimulus sequencing.
    initial begin
        t_traffic phase_modes [4];
        int       app_pct;
        int       del_pct;
        phase_modes = '{TR_STEADY, TR_SRC_SLOW, TR_SNK_SLOW, TR_BOTH_SLOW};
        value_pool[0] = INT_MIN;
        value_pool[1] = INT_MAX;
        value_pool[2] = 0;
        value_pool[3] = -1;
        value_pool[4] = 1;
        for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_traffic(TR_STEADY);

        // Empty store: nothing matches and the statistics take their empty values.
        queue_cmd(OP_SEARCH, 5, $urandom);
        queue_cmd(OP_DELETE, 5, $urandom);
        queue_cmd(OP_EDIT, 5, INT_MIN);
        // Field extremes and a duplicate.
        queue_cmd(OP_APPEND, INT_MAX, INT_MIN);
        queue_cmd(OP_APPEND, INT_MIN, INT_MAX);
        queue_cmd(OP_APPEND, 0, -1);
        queue_cmd(OP_APPEND, -1, 0);
        queue_cmd(OP_APPEND, INT_MAX, $urandom);
        queue_cmd(OP_SEARCH, INT_MAX, $urandom);
        queue_cmd(OP_SEARCH, -1, $urandom);
        queue_cmd(OP_SEARCH, 12345, $urandom);
        // Edit touches only the first of the two equal entries.
        queue_cmd(OP_EDIT, INT_MAX, 7);
        queue_cmd(OP_SEARCH, INT_MAX, $urandom);
        queue_cmd(OP_EDIT, 0, INT_MIN);
        queue_cmd(OP_EDIT, 42, 9);
        // Delete at the head, at the tail, then the first of two equal entries at the head.
        queue_cmd(OP_DELETE, 7, $urandom);
        queue_cmd(OP_DELETE, INT_MAX, $urandom);
        queue_cmd(OP_DELETE, INT_MIN, $urandom);
        // Negative sum checks truncation toward zero.
        queue_cmd(OP_APPEND, -7, $urandom);
        queue_cmd(OP_APPEND, 2, $urandom);
        queue_cmd(OP_DELETE, INT_MIN, $urandom);
        queue_cmd(OP_DELETE, -1, $urandom);
        queue_cmd(OP_DELETE, -7, $urandom);
        queue_cmd(OP_DELETE, 2, $urandom);
        wait_idle();

        // Random phases: first fill past capacity, then mix, then drain, then mix.
        for (int p = 0; p < 4; p++) begin
            set_traffic(phase_modes[p]);
            phase_num = p + 1;
            app_pct = (p == 0) ? 80 : (p == 2) ? 15 : 45;
            del_pct = (p == 0) ? 5 : (p == 2) ? 60 : 25;
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_cmds.push_back(random_list_cmd(app_pct, del_pct, 10));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/ovle_pkg.sv
src/ovle_ctrl.sv
src/ovle_div.sv
src/ovle_dp.sv
src/ordered_value_list_engine_top.sv
src/ovle_checker.sv
tb/tb.sv
